[hw/rtl/attc_pkg.sv]
// Shared constants, codes and the result record of the aging tile tag cache.
package attc_pkg;

   localparam int DEF_CACHE_ENTRIES   = 64;
   localparam int DEF_PENDING_ENTRIES = 16;
   localparam int DEF_COORD_BITS      = 16;

   localparam int FIELD_BITS = 16;
   localparam int SLOT_BITS  = 6;
   localparam int AGE_BITS   = 16;

   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   localparam logic MODE_LOOKUP = 1'b0;
   localparam logic MODE_INSERT = 1'b1;

   typedef struct packed {
      logic                         hit;
      logic [SLOT_BITS-1:0]         slot;
      logic                         request_issue;
      logic                         pending_full;
      logic                         evicted;
      logic signed [FIELD_BITS-1:0] evicted_x;
      logic signed [FIELD_BITS-1:0] evicted_y;
      logic                         pending_cleared;
   } rsp_type;

endpackage

[hw/rtl/aging_tile_tag_cache.sv]
// Top level of the aging tile tag cache: sequencer, tag and pending memories, output register.
//
// Request channel (req_): mode 0 looks a tile up, mode 1 inserts an arrived tile;
// the window fields are used on insert only. Response channel (rsp_): one response
// per request, in order. Both channels use valid/ready.
// The block works on one request at a time. A request walks the filled tag entries
// one per cycle through the tag memory read port, then all pending entries one per
// cycle through the pending memory read port. A lookup hit stops at the matching
// entry; an insert that clears a pending entry stops at that entry.
// The next request is taken in the cycle after the response is loaded into the
// output register.
// Reset clears the fill count and the pending valid bits at once; tag and pending
// memories are not cleared and need no clearing pass.
// While the receiver stalls, the response holds in the output register and the
// next request is still accepted and processed; a second finished response waits
// inside the sequencer until the output register frees.
module aging_tile_tag_cache
   import attc_pkg::*;
#(
   parameter int CACHE_ENTRIES   = DEF_CACHE_ENTRIES,
   parameter int PENDING_ENTRIES = DEF_PENDING_ENTRIES,
   parameter int COORD_BITS      = DEF_COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [FIELD_BITS-1:0] req_tile_x,
   input  logic signed [FIELD_BITS-1:0] req_tile_y,
   input  logic signed [FIELD_BITS-1:0] req_win_left,
   input  logic signed [FIELD_BITS-1:0] req_win_right,
   input  logic signed [FIELD_BITS-1:0] req_win_top,
   input  logic signed [FIELD_BITS-1:0] req_win_bottom,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_hit,
   output logic [SLOT_BITS-1:0]         rsp_slot,
   output logic                         rsp_request_issue,
   output logic                         rsp_pending_full,
   output logic                         rsp_evicted,
   output logic signed [FIELD_BITS-1:0] rsp_evicted_x,
   output logic signed [FIELD_BITS-1:0] rsp_evicted_y,
   output logic                         rsp_pending_cleared
);

   localparam int CW      = $clog2(CACHE_ENTRIES);
   localparam int PW      = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1;
   localparam int CACHE_W = 2 * COORD_BITS + AGE_BITS;
   localparam int PEND_W  = 2 * COORD_BITS;

   logic               cache_wr_en;
   logic [CW-1:0]      cache_wr_addr;
   logic [CACHE_W-1:0] cache_wr_data;
   logic [CW-1:0]      cache_rd_addr;
   logic [CACHE_W-1:0] cache_rd_data;
   logic               pend_wr_en;
   logic [PW-1:0]      pend_wr_addr;
   logic [PEND_W-1:0]  pend_wr_data;
   logic [PW-1:0]      pend_rd_addr;
   logic [PEND_W-1:0]  pend_rd_data;
   logic               res_valid;
   logic               res_ready;
   rsp_type            res;
   rsp_type            rsp;

   attc_seq #(
      .CACHE_ENTRIES  (CACHE_ENTRIES),
      .PENDING_ENTRIES(PENDING_ENTRIES),
      .COORD_BITS     (COORD_BITS)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_mode      (req_mode),
      .req_tile_x    (req_tile_x),
      .req_tile_y    (req_tile_y),
      .req_win_left  (req_win_left),
      .req_win_right (req_win_right),
      .req_win_top   (req_win_top),
      .req_win_bottom(req_win_bottom),
      .cache_wr_en   (cache_wr_en),
      .cache_wr_addr (cache_wr_addr),
      .cache_wr_data (cache_wr_data),
      .cache_rd_addr (cache_rd_addr),
      .cache_rd_data (cache_rd_data),
      .pend_wr_en    (pend_wr_en),
      .pend_wr_addr  (pend_wr_addr),
      .pend_wr_data  (pend_wr_data),
      .pend_rd_addr  (pend_rd_addr),
      .pend_rd_data  (pend_rd_data),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res           (res)
   );

   attc_ram #(
      .WIDTH(CACHE_W),
      .DEPTH(CACHE_ENTRIES)
   ) u_tag_ram (
      .clock  (clock),
      .wr_en  (cache_wr_en),
      .wr_addr(cache_wr_addr),
      .wr_data(cache_wr_data),
      .rd_addr(cache_rd_addr),
      .rd_data(cache_rd_data)
   );

   attc_ram #(
      .WIDTH(PEND_W),
      .DEPTH(PENDING_ENTRIES)
   ) u_pend_ram (
      .clock  (clock),
      .wr_en  (pend_wr_en),
      .wr_addr(pend_wr_addr),
      .wr_data(pend_wr_data),
      .rd_addr(pend_rd_addr),
      .rd_data(pend_rd_data)
   );

   attc_out u_out (
      .clock    (clock),
      .reset    (reset),
      .res_valid(res_valid),
      .res_ready(res_ready),
      .res      (res),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   assign rsp_hit             = rsp.hit;
   assign rsp_slot            = rsp.slot;
   assign rsp_request_issue   = rsp.request_issue;
   assign rsp_pending_full    = rsp.pending_full;
   assign rsp_evicted         = rsp.evicted;
   assign rsp_evicted_x       = rsp.evicted_x;
   assign rsp_evicted_y       = rsp.evicted_y;
   assign rsp_pending_cleared = rsp.pending_cleared;

`ifndef NO_ASSERTIONS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted while a request is in progress");

   a_hit_excludes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_hit) |->
         (!rsp_request_issue && !rsp_evicted && !rsp_pending_cleared))
      else $error("hit response carries miss or insert flags");

   a_full_needs_issue: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_pending_full) |-> rsp_request_issue)
      else $error("pending table full reported without a request");

   a_no_evict_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_evicted) |-> ((rsp_evicted_x == '0) && (rsp_evicted_y == '0)))
      else $error("evicted coordinates set without an eviction");
`endif

endmodule

[hw/rtl/attc_ram.sv]
// Generic single-clock RAM with one write port and one registered read port.
module attc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/attc_seq.sv]
// Sequencer: scans the tag memory and the pending memory for one request.
module attc_seq
   import attc_pkg::*;
#(
   parameter int CACHE_ENTRIES   = DEF_CACHE_ENTRIES,
   parameter int PENDING_ENTRIES = DEF_PENDING_ENTRIES,
   parameter int COORD_BITS      = DEF_COORD_BITS,
   localparam int CW     = $clog2(CACHE_ENTRIES),
   localparam int PW     = (PENDING_ENTRIES > 1) ? $clog2(PENDING_ENTRIES) : 1,
   localparam int CACHE_W = 2 * COORD_BITS + AGE_BITS,
   localparam int PEND_W  = 2 * COORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [FIELD_BITS-1:0] req_tile_x,
   input  logic signed [FIELD_BITS-1:0] req_tile_y,
   input  logic signed [FIELD_BITS-1:0] req_win_left,
   input  logic signed [FIELD_BITS-1:0] req_win_right,
   input  logic signed [FIELD_BITS-1:0] req_win_top,
   input  logic signed [FIELD_BITS-1:0] req_win_bottom,
   output logic                         cache_wr_en,
   output logic [CW-1:0]                cache_wr_addr,
   output logic [CACHE_W-1:0]           cache_wr_data,
   output logic [CW-1:0]                cache_rd_addr,
   input  logic [CACHE_W-1:0]           cache_rd_data,
   output logic                         pend_wr_en,
   output logic [PW-1:0]                pend_wr_addr,
   output logic [PEND_W-1:0]            pend_wr_data,
   output logic [PW-1:0]                pend_rd_addr,
   input  logic [PEND_W-1:0]            pend_rd_data,
   output logic                         res_valid,
   input  logic                         res_ready,
   output rsp_type                      res
);

   localparam int CNT_W  = $clog2(CACHE_ENTRIES + 1);
   localparam int PCNT_W = $clog2(PENDING_ENTRIES + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_PEND,
      ST_DONE
   } state_type;

   state_type state_ff, state_in;

   logic                          mode_ff, mode_in;
   logic signed [COORD_BITS-1:0]  x_ff, x_in, y_ff, y_in;
   logic signed [COORD_BITS-1:0]  wl_ff, wl_in, wr_ff, wr_in, wt_ff, wt_in, wb_ff, wb_in;
   logic [CNT_W-1:0]              n_ff, n_in, fill_ff, fill_in, cnt_ff, cnt_in;
   logic                          chk_ff, chk_in;
   logic [CW-1:0]                 chk_idx_ff, chk_idx_in;
   logic [PCNT_W-1:0]             pcnt_ff, pcnt_in;
   logic                          pchk_ff, pchk_in;
   logic [PW-1:0]                 pchk_idx_ff, pchk_idx_in;
   logic [PENDING_ENTRIES-1:0]    pv_ff, pv_in;
   logic [AGE_BITS-1:0]           oldest_ff, oldest_in;
   logic [CW-1:0]                 dst_ff, dst_in;
   logic signed [COORD_BITS-1:0]  evx_ff, evx_in, evy_ff, evy_in;
   logic                          pend_hit_ff, pend_hit_in;
   logic                          free_ok_ff, free_ok_in;
   logic [PW-1:0]                 free_idx_ff, free_idx_in;
   rsp_type                       res_ff, res_in;

   logic signed [COORD_BITS-1:0]  col, row, pcol, prow;
   logic [AGE_BITS-1:0]           age, aged;
   logic                          outside, match, issue, pissue, pvalid, pmatch, full;

   assign col  = cache_rd_data[CACHE_W-1 -: COORD_BITS];
   assign row  = cache_rd_data[AGE_BITS+COORD_BITS-1 -: COORD_BITS];
   assign age  = cache_rd_data[AGE_BITS-1:0];
   assign pcol = pend_rd_data[PEND_W-1 -: COORD_BITS];
   assign prow = pend_rd_data[COORD_BITS-1:0];

   assign match   = (col == x_ff) && (row == y_ff);
   assign outside = (col < wl_ff) || (col > wr_ff) || (row > wt_ff) || (row < wb_ff);
   assign aged    = (outside && (age != AGE_MAX)) ? age + AGE_BITS'(1) : age;
   assign issue   = cnt_ff < n_ff;
   assign pissue  = pcnt_ff < PCNT_W'(PENDING_ENTRIES);
   assign pvalid  = pv_ff[pchk_idx_ff];
   assign pmatch  = pvalid && (pcol == x_ff) && (prow == y_ff);
   assign full    = n_ff == CNT_W'(CACHE_ENTRIES);

   assign req_ready     = state_ff == ST_IDLE;
   assign res_valid     = state_ff == ST_DONE;
   assign res           = res_ff;
   assign cache_rd_addr = cnt_ff[CW-1:0];
   assign pend_rd_addr  = pcnt_ff[PW-1:0];

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      x_in        = x_ff;
      y_in        = y_ff;
      wl_in       = wl_ff;
      wr_in       = wr_ff;
      wt_in       = wt_ff;
      wb_in       = wb_ff;
      n_in        = n_ff;
      fill_in     = fill_ff;
      cnt_in      = cnt_ff;
      chk_in      = chk_ff;
      chk_idx_in  = chk_idx_ff;
      pcnt_in     = pcnt_ff;
      pchk_in     = pchk_ff;
      pchk_idx_in = pchk_idx_ff;
      pv_in       = pv_ff;
      oldest_in   = oldest_ff;
      dst_in      = dst_ff;
      evx_in      = evx_ff;
      evy_in      = evy_ff;
      pend_hit_in = pend_hit_ff;
      free_ok_in  = free_ok_ff;
      free_idx_in = free_idx_ff;
      res_in      = res_ff;

      cache_wr_en   = 1'b0;
      cache_wr_addr = chk_idx_ff;
      cache_wr_data = {col, row, aged};
      pend_wr_en    = 1'b0;
      pend_wr_addr  = free_idx_ff;
      pend_wr_data  = {x_ff, y_ff};

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in     = req_mode;
               x_in        = COORD_BITS'(req_tile_x);
               y_in        = COORD_BITS'(req_tile_y);
               wl_in       = COORD_BITS'(req_win_left);
               wr_in       = COORD_BITS'(req_win_right);
               wt_in       = COORD_BITS'(req_win_top);
               wb_in       = COORD_BITS'(req_win_bottom);
               n_in        = fill_ff;
               cnt_in      = '0;
               chk_in      = 1'b0;
               pcnt_in     = '0;
               pchk_in     = 1'b0;
               oldest_in   = '0;
               dst_in      = '0;
               evx_in      = '0;
               evy_in      = '0;
               pend_hit_in = 1'b0;
               free_ok_in  = 1'b0;
               res_in      = '0;
               state_in    = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            chk_in     = issue;
            chk_idx_in = cnt_ff[CW-1:0];
            if (chk_ff) begin
               if (mode_ff == MODE_LOOKUP) begin
                  if (match) begin
                     cache_wr_en   = 1'b1;
                     cache_wr_data = {col, row, {AGE_BITS{1'b0}}};
                     res_in.hit    = 1'b1;
                     res_in.slot   = SLOT_BITS'(chk_idx_ff);
                     chk_in        = 1'b0;
                     state_in      = ST_DONE;
                  end
               end else begin
                  cache_wr_en = 1'b1;
                  if (chk_idx_ff == '0) begin
                     evx_in = col;
                     evy_in = row;
                  end
                  if (aged > oldest_ff) begin
                     oldest_in = aged;
                     dst_in    = chk_idx_ff;
                     evx_in    = col;
                     evy_in    = row;
                  end
               end
            end else if (!issue) begin
               state_in = (mode_ff == MODE_LOOKUP) ? ST_PEND : ST_FILL;
            end
         end
         ST_FILL: begin
            cache_wr_en   = 1'b1;
            cache_wr_data = {x_ff, y_ff, {AGE_BITS{1'b0}}};
            if (full) begin
               cache_wr_addr    = dst_ff;
               res_in.evicted   = 1'b1;
               res_in.evicted_x = FIELD_BITS'(evx_ff);
               res_in.evicted_y = FIELD_BITS'(evy_ff);
               res_in.slot      = SLOT_BITS'(dst_ff);
            end else begin
               cache_wr_addr = n_ff[CW-1:0];
               fill_in       = fill_ff + CNT_W'(1);
               res_in.slot   = SLOT_BITS'(n_ff[CW-1:0]);
            end
            state_in = ST_PEND;
         end
         ST_PEND: begin
            if (pissue) begin
               pcnt_in = pcnt_ff + PCNT_W'(1);
            end
            pchk_in     = pissue;
            pchk_idx_in = pcnt_ff[PW-1:0];
            if (pchk_ff) begin
               if (mode_ff == MODE_LOOKUP) begin
                  if (pmatch) begin
                     pend_hit_in = 1'b1;
                  end
                  if (!pvalid && !free_ok_ff) begin
                     free_ok_in  = 1'b1;
                     free_idx_in = pchk_idx_ff;
                  end
               end else if (pmatch) begin
                  pv_in[pchk_idx_ff]     = 1'b0;
                  res_in.pending_cleared = 1'b1;
                  pchk_in                = 1'b0;
                  state_in               = ST_DONE;
               end
            end else if (!pissue) begin
               if ((mode_ff == MODE_LOOKUP) && !pend_hit_ff) begin
                  res_in.request_issue = 1'b1;
                  if (free_ok_ff) begin
                     pend_wr_en         = 1'b1;
                     pv_in[free_idx_ff] = 1'b1;
                  end else begin
                     res_in.pending_full = 1'b1;
                  end
               end
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         fill_ff  <= '0;
         pv_ff    <= '0;
         chk_ff   <= 1'b0;
         pchk_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_ff  <= fill_in;
         pv_ff    <= pv_in;
         chk_ff   <= chk_in;
         pchk_ff  <= pchk_in;
      end
      mode_ff     <= mode_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      wl_ff       <= wl_in;
      wr_ff       <= wr_in;
      wt_ff       <= wt_in;
      wb_ff       <= wb_in;
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      chk_idx_ff  <= chk_idx_in;
      pcnt_ff     <= pcnt_in;
      pchk_idx_ff <= pchk_idx_in;
      oldest_ff   <= oldest_in;
      dst_ff      <= dst_in;
      evx_ff      <= evx_in;
      evy_ff      <= evy_in;
      pend_hit_ff <= pend_hit_in;
      free_ok_ff  <= free_ok_in;
      free_idx_ff <= free_idx_in;
      res_ff      <= res_in;
   end

endmodule

[hw/rtl/attc_out.sv]
// Output register of the response channel.
module attc_out
   import attc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    res_valid,
   output logic    res_ready,
   input  rsp_type res,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   assign res_ready = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (res_ready) begin
         valid_in = res_valid;
         if (res_valid) begin
            data_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp       = data_ff;

endmodule

[verif/tile_cache_checker.sv]
// Request/response monitor for the aging tile tag cache: predicts each response and compares it.
`timescale 1ns / 100ps

module tile_cache_checker
   import attc_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic                         req_mode,
   input  logic signed [FIELD_BITS-1:0] req_tile_x,
   input  logic signed [FIELD_BITS-1:0] req_tile_y,
   input  logic signed [FIELD_BITS-1:0] req_win_left,
   input  logic signed [FIELD_BITS-1:0] req_win_right,
   input  logic signed [FIELD_BITS-1:0] req_win_top,
   input  logic signed [FIELD_BITS-1:0] req_win_bottom,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic                         rsp_hit,
   input  logic [SLOT_BITS-1:0]         rsp_slot,
   input  logic                         rsp_request_issue,
   input  logic                         rsp_pending_full,
   input  logic                         rsp_evicted,
   input  logic signed [FIELD_BITS-1:0] rsp_evicted_x,
   input  logic signed [FIELD_BITS-1:0] rsp_evicted_y,
   input  logic                         rsp_pending_cleared,
   output int                           mismatches,
   output int                           awaited
);

   localparam int REPORT_MAX = 100;

   logic signed [FIELD_BITS-1:0] tag_x [DEF_CACHE_ENTRIES];
   logic signed [FIELD_BITS-1:0] tag_y [DEF_CACHE_ENTRIES];
   logic [AGE_BITS-1:0]          tag_age [DEF_CACHE_ENTRIES];
   int                           filled;
   logic signed [FIELD_BITS-1:0] fetch_x [DEF_PENDING_ENTRIES];
   logic signed [FIELD_BITS-1:0] fetch_y [DEF_PENDING_ENTRIES];
   logic                         fetch_live [DEF_PENDING_ENTRIES];
   rsp_type                      awaited_rsp [$];

   task automatic lookup_tile(input logic signed [FIELD_BITS-1:0] x, y, output rsp_type r);
      bit found, busy;
      int free;
      r     = '0;
      found = 0;
      busy  = 0;
      free  = -1;
      for (int i = 0; i < filled; i++) begin
         if (!found && tag_x[i] == x && tag_y[i] == y) begin
            tag_age[i] = '0;
            r.hit      = 1'b1;
            r.slot     = SLOT_BITS'(i);
            found      = 1;
         end
      end
      if (!found) begin
         for (int i = 0; i < DEF_PENDING_ENTRIES; i++) begin
            if (fetch_live[i]) begin
               if (fetch_x[i] == x && fetch_y[i] == y) busy = 1;
            end else if (free < 0) begin
               free = i;
            end
         end
         if (!busy) begin
            r.request_issue = 1'b1;
            if (free < 0) begin
               r.pending_full = 1'b1;
            end else begin
               fetch_x[free]    = x;
               fetch_y[free]    = y;
               fetch_live[free] = 1'b1;
            end
         end
      end
   endtask

   task automatic insert_tile(input logic signed [FIELD_BITS-1:0] x, y, wl, wr, wt, wb,
                              output rsp_type r);
      int dst;
      logic [AGE_BITS-1:0] oldest;
      bit cleared;
      r       = '0;
      cleared = 0;
      for (int i = 0; i < filled; i++) begin
         if (tag_x[i] < wl || tag_x[i] > wr || tag_y[i] > wt || tag_y[i] < wb) begin
            if (tag_age[i] != AGE_MAX) tag_age[i] = tag_age[i] + 1'b1;
         end
      end
      if (filled >= DEF_CACHE_ENTRIES) begin
         oldest = '0;
         dst    = 0;
         for (int i = 0; i < DEF_CACHE_ENTRIES; i++) begin
            if (tag_age[i] > oldest) begin
               oldest = tag_age[i];
               dst    = i;
            end
         end
         r.evicted   = 1'b1;
         r.evicted_x = tag_x[dst];
         r.evicted_y = tag_y[dst];
      end else begin
         dst    = filled;
         filled = filled + 1;
      end
      tag_x[dst]   = x;
      tag_y[dst]   = y;
      tag_age[dst] = '0;
      r.slot       = SLOT_BITS'(dst);
      for (int i = 0; i < DEF_PENDING_ENTRIES; i++) begin
         if (!cleared && fetch_live[i] && fetch_x[i] == x && fetch_y[i] == y) begin
            fetch_live[i]     = 1'b0;
            r.pending_cleared = 1'b1;
            cleared           = 1;
         end
      end
   endtask

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         mismatches = 0;
         filled     = 0;
         for (int i = 0; i < DEF_PENDING_ENTRIES; i++) fetch_live[i] = 1'b0;
         awaited_rsp.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got = '{hit: rsp_hit, slot: rsp_slot, request_issue: rsp_request_issue,
                    pending_full: rsp_pending_full, evicted: rsp_evicted,
                    evicted_x: rsp_evicted_x, evicted_y: rsp_evicted_y,
                    pending_cleared: rsp_pending_cleared};
            if (awaited_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: response with no request waiting, actual %p", $time, got);
            end else begin
               want = awaited_rsp.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: expected %p, actual %p", $time, want, got);
               end
            end
         end
         if (req_valid && req_ready) begin
            if (req_mode == MODE_INSERT)
               insert_tile(req_tile_x, req_tile_y, req_win_left, req_win_right,
                           req_win_top, req_win_bottom, want);
            else
               lookup_tile(req_tile_x, req_tile_y, want);
            awaited_rsp.push_back(want);
         end
      end
      awaited = awaited_rsp.size();
   end

endmodule

[verif/aging_tile_tag_cache_test.sv]
// Top of the aging tile tag cache testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module aging_tile_tag_cache_test;
   import attc_pkg::*;

   localparam int ITEM_COUNT  = 1600;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int POOL_MAX    = 96;
   localparam logic signed [FIELD_BITS-1:0] COORD_LO = 16'sh8000;
   localparam logic signed [FIELD_BITS-1:0] COORD_HI = 16'sh7FFF;

   logic                         clock;
   logic                         reset;
   logic                         req_valid;
   logic                         req_ready;
   logic                         req_mode;
   logic signed [FIELD_BITS-1:0] req_tile_x;
   logic signed [FIELD_BITS-1:0] req_tile_y;
   logic signed [FIELD_BITS-1:0] req_win_left;
   logic signed [FIELD_BITS-1:0] req_win_right;
   logic signed [FIELD_BITS-1:0] req_win_top;
   logic signed [FIELD_BITS-1:0] req_win_bottom;
   logic                         rsp_valid;
   logic                         rsp_ready;
   logic                         rsp_hit;
   logic [SLOT_BITS-1:0]         rsp_slot;
   logic                         rsp_request_issue;
   logic                         rsp_pending_full;
   logic                         rsp_evicted;
   logic signed [FIELD_BITS-1:0] rsp_evicted_x;
   logic signed [FIELD_BITS-1:0] rsp_evicted_y;
   logic                         rsp_pending_cleared;

   int mismatches;
   int awaited;
   int cycles = 0;
   int sent   = 0;
   bit calm   = 0;

   logic signed [FIELD_BITS-1:0] pool_x [POOL_MAX];
   logic signed [FIELD_BITS-1:0] pool_y [POOL_MAX];

   aging_tile_tag_cache dut (.*);

   tile_cache_checker watch (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("aging_tile_tag_cache: mismatch");
         $finish;
      end
   end

   task automatic send_request(input logic mode,
                               input logic signed [FIELD_BITS-1:0] x, y, wl, wr, wt, wb);
      int gap;
      gap = calm ? 0 : $urandom_range(0, 12);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_tile_x     <= x;
      req_tile_y     <= y;
      req_win_left   <= wl;
      req_win_right  <= wr;
      req_win_top    <= wt;
      req_win_bottom <= wb;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   task automatic pick_window(input bit full_view,
                              output logic signed [FIELD_BITS-1:0] wl, wr, wt, wb);
      int pick;
      pick = full_view ? 0 : $urandom_range(0, 9);
      if (pick < 2) begin
         wl = COORD_LO;
         wr = COORD_HI;
         wt = COORD_HI;
         wb = COORD_LO;
      end else if (pick < 7) begin
         wl = FIELD_BITS'(-int'($urandom_range(0, 10)));
         wr = FIELD_BITS'($urandom_range(0, 10));
         wt = FIELD_BITS'($urandom_range(0, 10));
         wb = FIELD_BITS'(-int'($urandom_range(0, 10)));
      end else if (pick == 7) begin
         wl = FIELD_BITS'($urandom_range(1, 10));
         wr = FIELD_BITS'(-int'($urandom_range(0, 10)));
         wt = FIELD_BITS'(-int'($urandom_range(0, 10)));
         wb = FIELD_BITS'($urandom_range(1, 10));
      end else begin
         wl = FIELD_BITS'($urandom);
         wr = FIELD_BITS'($urandom);
         wt = FIELD_BITS'($urandom);
         wb = FIELD_BITS'($urandom);
      end
   endtask

   initial begin : drain
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         stall = calm ? 0 : $urandom_range(0, 12);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin : stimulus
      int seg_len, pool_size, insert_pct, k;
      bit full_view;
      logic signed [FIELD_BITS-1:0] wl, wr, wt, wb;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_LOOKUP;
      req_tile_x     = '0;
      req_tile_y     = '0;
      req_win_left   = '0;
      req_win_right  = '0;
      req_win_top    = '0;
      req_win_bottom = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // miss, already pending, insert clearing it, then hit
      send_request(MODE_LOOKUP, 0, 0, 0, 0, 0, 0);
      send_request(MODE_LOOKUP, 0, 0, 0, 0, 0, 0);
      send_request(MODE_INSERT, 0, 0, COORD_LO, COORD_HI, COORD_HI, COORD_LO);
      send_request(MODE_LOOKUP, 0, 0, 0, 0, 0, 0);
      // coordinate extremes, inverted and narrow windows
      send_request(MODE_INSERT, COORD_LO, COORD_HI, COORD_HI, COORD_LO, COORD_LO, COORD_HI);
      send_request(MODE_INSERT, COORD_HI, COORD_LO, -1, 1, 1, -1);
      send_request(MODE_LOOKUP, COORD_HI, COORD_LO, 0, 0, 0, 0);
      send_request(MODE_LOOKUP, COORD_LO, COORD_HI, 0, 0, 0, 0);
      // duplicate insert, lowest slot wins
      send_request(MODE_INSERT, 0, 0, 0, 0, 0, 0);
      send_request(MODE_LOOKUP, 0, 0, 0, 0, 0, 0);
      send_request(MODE_LOOKUP, -1, -1, 16'sh5555, 16'shAAAA, 16'sh5555, 16'shAAAA);
      send_request(MODE_INSERT, -1, -1, 16'shAAAA, 16'sh5555, 16'shAAAA, 16'sh5555);
      send_request(MODE_LOOKUP, 16'sh5555, 16'shAAAA, 0, 0, 0, 0);
      send_request(MODE_INSERT, 16'shAAAA, 16'sh5555, COORD_HI, COORD_HI, COORD_LO, COORD_LO);
      send_request(MODE_LOOKUP, 16'shAAAA, 16'sh5555, COORD_LO, COORD_LO, COORD_HI, COORD_HI);

      while (sent < ITEM_COUNT) begin
         seg_len = $urandom_range(40, 160);
         case ($urandom_range(0, 2))
            0: pool_size = 4;
            1: pool_size = 24;
            default: pool_size = POOL_MAX;
         endcase
         case ($urandom_range(0, 2))
            0: insert_pct = 10;
            1: insert_pct = 40;
            default: insert_pct = 70;
         endcase
         full_view = ($urandom_range(0, 4) == 0);
         calm      = ($urandom_range(0, 4) == 0);
         for (int i = 0; i < pool_size; i++) begin
            if ($urandom_range(0, 99) < 12) begin
               pool_x[i] = FIELD_BITS'($urandom);
               pool_y[i] = FIELD_BITS'($urandom);
            end else begin
               pool_x[i] = FIELD_BITS'(int'($urandom_range(0, 15)) - 8);
               pool_y[i] = FIELD_BITS'(int'($urandom_range(0, 15)) - 8);
            end
         end
         repeat (seg_len) begin
            k = $urandom_range(0, pool_size - 1);
            pick_window(full_view, wl, wr, wt, wb);
            if ($urandom_range(0, 99) < insert_pct)
               send_request(MODE_INSERT, pool_x[k], pool_y[k], wl, wr, wt, wb);
            else
               send_request(MODE_LOOKUP, pool_x[k], pool_y[k], wl, wr, wt, wb);
         end
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (awaited != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if ((mismatches == 0) && (awaited == 0))
         $display("aging_tile_tag_cache: match");
      else
         $display("aging_tile_tag_cache: mismatch");
      $finish;
   end

endmodule
